FILE: src/afd_pkg.sv
`timescale 1ns / 1ps

package afd_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned KindW   = 2;
  localparam int unsigned StatusW = 2;
  localparam int unsigned LenW    = 16;

  // Start delimiter after reset.
  localparam logic [ByteW-1:0] StartDelimReset = 8'h7E;
  // A well-formed frame sums to this value over data and checksum.
  localparam logic [ByteW-1:0] SumGood = 8'hFF;

  // Kind of a result beat.
  localparam logic [KindW-1:0] KindType    = 2'd0;
  localparam logic [KindW-1:0] KindPayload = 2'd1;
  localparam logic [KindW-1:0] KindVerdict = 2'd2;

  // Verdict codes.
  localparam logic [StatusW-1:0] StOk       = 2'd0;
  localparam logic [StatusW-1:0] StBadStart = 2'd1;
  localparam logic [StatusW-1:0] StLength   = 2'd2;
  localparam logic [StatusW-1:0] StChecksum = 2'd3;

  // One received beat held in the input register.
  typedef struct packed {
    logic             last;
    logic [ByteW-1:0] rx_byte;
  } in_beat_t;

  // One result beat.
  typedef struct packed {
    logic [LenW-1:0]    frame_length;
    logic [StatusW-1:0] status;
    logic [KindW-1:0]   out_kind;
    logic [ByteW-1:0]   out_byte;
  } result_t;

endpackage

FILE: src/afd_in_reg.sv
`timescale 1ns / 1ps

// Input register stage. Takes a beat whenever it is empty or being drained.
module afd_in_reg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  afd_pkg::in_beat_t beat_i,
  output logic             valid_o,
  input  logic             take_i,
  output afd_pkg::in_beat_t beat_o
);

  logic              valid_q;
  logic              valid_d;
  afd_pkg::in_beat_t beat_q;

  assign ready_o = !valid_q || take_i;
  assign valid_d = valid_i ? 1'b1 : (valid_q && !take_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      beat_q <= beat_i;
    end
  end

  assign valid_o = valid_q;
  assign beat_o  = beat_q;

endmodule

FILE: src/afd_core.sv
`timescale 1ns / 1ps

// Frame parser state and per-byte decision logic.
module afd_core (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [afd_pkg::ByteW-1:0] cfg_wdata_i,
  input  logic                     fire_i,
  input  afd_pkg::in_beat_t        beat_i,
  output logic                     res_valid_o,
  output afd_pkg::result_t         res_o
);

  localparam logic [2:0] PhStart   = 3'd0;
  localparam logic [2:0] PhLenHi   = 3'd1;
  localparam logic [2:0] PhLenLo   = 3'd2;
  localparam logic [2:0] PhType    = 3'd3;
  localparam logic [2:0] PhPayload = 3'd4;
  localparam logic [2:0] PhCheck   = 3'd5;
  localparam logic [2:0] PhDrain   = 3'd6;

  logic [afd_pkg::ByteW-1:0]   delim_q;
  logic [2:0]                  phase_q, phase_d;
  logic [afd_pkg::LenW-1:0]    remain_q, remain_d;
  logic [afd_pkg::ByteW-1:0]   sum_q, sum_d;
  logic [afd_pkg::StatusW-1:0] err_q, err_d;
  logic [afd_pkg::LenW-1:0]    hlen_q, hlen_d;
  logic                        checked;
  logic                        fwd;
  logic [afd_pkg::KindW-1:0]   kind;
  logic [afd_pkg::StatusW-1:0] verdict;
  logic [afd_pkg::ByteW-1:0]   b;

  assign b = beat_i.rx_byte;

  always_comb begin
    phase_d  = phase_q;
    remain_d = remain_q;
    sum_d    = sum_q;
    err_d    = err_q;
    hlen_d   = hlen_q;
    checked  = 1'b0;
    fwd      = 1'b0;
    kind     = afd_pkg::KindType;
    verdict  = afd_pkg::StOk;
    res_valid_o = 1'b0;
    res_o       = '0;

    unique case (phase_q)
      PhStart: begin
        if (b != delim_q) begin
          err_d   = afd_pkg::StBadStart;
          phase_d = PhDrain;
        end else begin
          phase_d = PhLenHi;
        end
      end
      PhLenHi: begin
        hlen_d  = {b, {afd_pkg::ByteW{1'b0}}};
        phase_d = PhLenLo;
      end
      PhLenLo: begin
        hlen_d   = {hlen_q[afd_pkg::LenW-1:afd_pkg::ByteW], b};
        remain_d = hlen_d;
        sum_d    = '0;
        phase_d  = (hlen_d != '0) ? PhType : PhCheck;
      end
      PhType, PhPayload: begin
        kind     = (phase_q == PhType) ? afd_pkg::KindType : afd_pkg::KindPayload;
        fwd      = 1'b1;
        sum_d    = sum_q + b;
        remain_d = remain_q - 1'b1;
        phase_d  = (remain_d != '0) ? PhPayload : PhCheck;
      end
      PhCheck: begin
        sum_d   = sum_q + b;
        checked = 1'b1;
        if (!beat_i.last) begin
          err_d   = afd_pkg::StLength;
          phase_d = PhDrain;
        end
      end
      default: begin
        // Draining after an error; the spare code behaves as a length error.
        if (err_q == afd_pkg::StOk) begin
          err_d = afd_pkg::StLength;
        end
        phase_d = PhDrain;
      end
    endcase

    if (err_d != afd_pkg::StOk) begin
      verdict = err_d;
    end else if (!checked) begin
      verdict = afd_pkg::StLength;
    end else begin
      verdict = (sum_d == afd_pkg::SumGood) ? afd_pkg::StOk : afd_pkg::StChecksum;
    end

    if (beat_i.last) begin
      res_valid_o        = 1'b1;
      res_o.out_kind     = afd_pkg::KindVerdict;
      res_o.status       = verdict;
      res_o.frame_length = hlen_d;
      phase_d  = PhStart;
      remain_d = '0;
      sum_d    = '0;
      err_d    = afd_pkg::StOk;
      hlen_d   = '0;
    end else if (fwd) begin
      res_valid_o    = 1'b1;
      res_o.out_byte = b;
      res_o.out_kind = kind;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delim_q  <= afd_pkg::StartDelimReset;
      phase_q  <= PhStart;
      remain_q <= '0;
      sum_q    <= '0;
      err_q    <= afd_pkg::StOk;
      hlen_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        delim_q <= cfg_wdata_i;
      end
      if (fire_i) begin
        phase_q  <= phase_d;
        remain_q <= remain_d;
        sum_q    <= sum_d;
        err_q    <= err_d;
        hlen_q   <= hlen_d;
      end
    end
  end

endmodule

FILE: src/afd_out_reg.sv
`timescale 1ns / 1ps

// Result register. Loads a new result when it is empty or while the held one is being taken.
module afd_out_reg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  afd_pkg::result_t res_i,
  output logic             space_o,
  output logic             valid_o,
  input  logic             ready_i,
  output afd_pkg::result_t res_o
);

  logic             valid_q;
  logic             valid_d;
  afd_pkg::result_t res_q;

  assign space_o = !valid_q || ready_i;
  assign valid_d = load_i ? 1'b1 : (valid_q && !ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

FILE: src/api_frame_deframer_checker_unit.sv
`timescale 1ns / 1ps

// A byte in the input register is parsed by the combinational parser step once the result
// register has room; its result, if any, is loaded there and offered on the result stream.
// Throughput: one byte per cycle while the result register has room, set by the parser
// step between the two registers. While a result waits, one more byte can be parked in
// the input register, and then the input stalls until the result register has room again.
// Reset: rst_ni clears both register stages, the parser state, and loads the delimiter 0x7E.
module api_frame_deframer_checker_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Received stream.
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] rx_byte
  input  logic        s_axis_tlast_i,   // buffer_end
  // Result stream.
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [7:0] out_byte, [9:8] status,
                                        // [25:10] frame_length, [31:26] zero
  output logic [1:0]  m_axis_tuser_o,   // [1:0] out_kind
  // Start delimiter register.
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i
);

  afd_pkg::in_beat_t in_beat;
  afd_pkg::in_beat_t held_beat;
  logic              held_valid;
  logic              out_space;
  logic              fire;
  logic              res_valid;
  afd_pkg::result_t  res;
  afd_pkg::result_t  out_res;

  assign in_beat.rx_byte = s_axis_tdata_i;
  assign in_beat.last    = s_axis_tlast_i;

  // A held byte is processed whenever the result register has room, even if it
  // produces no result; bytes without a result simply advance the parser.
  assign fire = held_valid && out_space;

  afd_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid_i),
    .ready_o (s_axis_tready_o),
    .beat_i  (in_beat),
    .valid_o (held_valid),
    .take_i  (fire),
    .beat_o  (held_beat)
  );

  afd_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .fire_i      (fire),
    .beat_i      (held_beat),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  afd_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (fire && res_valid),
    .res_i   (res),
    .space_o (out_space),
    .valid_o (m_axis_tvalid_o),
    .ready_i (m_axis_tready_i),
    .res_o   (out_res)
  );

  assign m_axis_tdata_o = {6'b0, out_res.frame_length, out_res.status, out_res.out_byte};
  assign m_axis_tuser_o = out_res.out_kind;

  // A verdict beat never carries a data byte.
  a_verdict_no_byte : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o == afd_pkg::KindVerdict)
      |-> m_axis_tdata_o[7:0] == 8'd0)
    else $error("verdict beat carries a nonzero byte");

  // Forwarded bytes carry neither status nor length.
  a_fwd_clean : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o != afd_pkg::KindVerdict)
      |-> m_axis_tdata_o[25:8] == 18'd0)
    else $error("forwarded beat carries status or length");

  // The spare kind code is never produced.
  a_kind_legal : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tuser_o != 2'd3)
    else $error("illegal result kind");

  // With the result register empty, the input side must be able to take a beat.
  a_ready_when_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("input stalled with an empty result register");

endmodule

FILE: verif/api_frame_deframer_checker_unit_tb.sv
`timescale 1ns / 1ps

module api_frame_deframer_checker_unit_tb;

  localparam int unsigned NumDirected = 25;
  localparam int unsigned ItemBudget  = 1250;
  localparam int unsigned NumPhases   = 4;
  localparam int unsigned CycleLimit  = 1000000;
  // Hold-off of the result side, long enough to back the block up into its input.
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned HoldAfter   = 400;
  // Cycles after the last result before the block is known to be quiet.
  localparam int unsigned QuietCycles = 6;

  // Parser phases of the frame-checking predictor.
  typedef enum logic [2:0] {
    PhStart, PhLenHi, PhLenLo, PhType, PhPayload, PhCheck, PhDrain
  } parse_phase_e;

  // One row of the directed table. When typed is set, the row must produce
  // exactly the result given in verdict; otherwise the predictor decides.
  typedef struct packed {
    logic [7:0]       rx_byte;
    logic             buffer_end;
    logic             typed;
    afd_pkg::result_t verdict;
  } directed_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i;
  logic        s_axis_tlast_i;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [31:0] m_axis_tdata_o;
  logic [1:0]  m_axis_tuser_o;
  logic        cfg_we_i;
  logic [7:0]  cfg_wdata_i;

  // Predictor state: a private copy of the parser and the delimiter register.
  parse_phase_e parse_phase;
  logic [15:0]  bytes_left;
  logic [15:0]  hdr_length;
  logic [7:0]   frame_sum;
  logic [1:0]   latched_err;
  logic [7:0]   delimiter;

  // Results that the block still owes, oldest first.
  afd_pkg::result_t frame_results_q [$];
  afd_pkg::result_t oldest_result;
  // Bytes of the buffer that is about to be sent.
  logic [7:0]   buffer_bytes [$];

  int unsigned  mismatch_count = 0;
  int unsigned  cycle_count = 0;
  int unsigned  beats_accepted = 0;

  // Directed table. Delimiter is the reset value 0x7E throughout.
  directed_row_t directed_rows [NumDirected] = '{
    // Wrong first byte: ignored until the end flag, which reports bad start.
    '{8'h00, 1'b0, 1'b0, 28'h0},
    '{8'hFF, 1'b1, 1'b1, {16'h0000, afd_pkg::StBadStart, afd_pkg::KindVerdict, 8'h00}},
    // Zero-length frame: the byte after the length is the checksum.
    '{8'h7E, 1'b0, 1'b0, 28'h0},
    '{8'h00, 1'b0, 1'b0, 28'h0},
    '{8'h00, 1'b0, 1'b0, 28'h0},
    '{8'hFF, 1'b1, 1'b1, {16'h0000, afd_pkg::StOk, afd_pkg::KindVerdict, 8'h00}},
    // Good two-byte frame: type byte and one payload byte are forwarded.
    '{8'h7E, 1'b0, 1'b0, 28'h0},
    '{8'h00, 1'b0, 1'b0, 28'h0},
    '{8'h02, 1'b0, 1'b0, 28'h0},
    '{8'h10, 1'b0, 1'b0, 28'h0},
    '{8'hEF, 1'b0, 1'b0, 28'h0},
    '{8'h00, 1'b1, 1'b1, {16'h0002, afd_pkg::StOk, afd_pkg::KindVerdict, 8'h00}},
    // Checksum that does not bring the sum to 0xFF.
    '{8'h7E, 1'b0, 1'b0, 28'h0},
    '{8'h00, 1'b0, 1'b0, 28'h0},
    '{8'h01, 1'b0, 1'b0, 28'h0},
    '{8'h00, 1'b0, 1'b0, 28'h0},
    '{8'h00, 1'b1, 1'b1, {16'h0001, afd_pkg::StChecksum, afd_pkg::KindVerdict, 8'h00}},
    // Buffer ends right after the high length byte.
    '{8'h7E, 1'b0, 1'b0, 28'h0},
    '{8'h80, 1'b1, 1'b1, {16'h8000, afd_pkg::StLength, afd_pkg::KindVerdict, 8'h00}},
    // Checksum not flagged as last: the tail is drained, then a length error.
    '{8'h7E, 1'b0, 1'b0, 28'h0},
    '{8'h00, 1'b0, 1'b0, 28'h0},
    '{8'h00, 1'b0, 1'b0, 28'h0},
    '{8'hFF, 1'b0, 1'b0, 28'h0},
    '{8'h55, 1'b1, 1'b1, {16'h0000, afd_pkg::StLength, afd_pkg::KindVerdict, 8'h00}},
    // Buffer that holds only the delimiter.
    '{8'h7E, 1'b1, 1'b1, {16'h0000, afd_pkg::StLength, afd_pkg::KindVerdict, 8'h00}}
  };

  api_frame_deframer_checker_unit u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Returns the parser to waiting for a start delimiter.
  function automatic void clear_parser();
    parse_phase = PhStart;
    bytes_left  = 16'h0000;
    frame_sum   = 8'h00;
    latched_err = afd_pkg::StOk;
    hdr_length  = 16'h0000;
  endfunction

  // Advances the predictor by one received byte. Returns 1 when the byte
  // produces a result beat, which is then placed in res.
  function automatic logic deframe_step(input logic [7:0] b, input logic last,
                                        output afd_pkg::result_t res);
    logic         checked;
    logic         forward;
    logic [1:0]   kind;
    logic [1:0]   verdict;
    checked = 1'b0;
    forward = 1'b0;
    kind    = afd_pkg::KindType;
    res     = '0;
    case (parse_phase)
      PhStart: begin
        if (b != delimiter) begin
          latched_err = afd_pkg::StBadStart;
          parse_phase = PhDrain;
        end else begin
          parse_phase = PhLenHi;
        end
      end
      PhLenHi: begin
        hdr_length  = {b, 8'h00};
        parse_phase = PhLenLo;
      end
      PhLenLo: begin
        hdr_length  = hdr_length | {8'h00, b};
        bytes_left  = hdr_length;
        frame_sum   = 8'h00;
        parse_phase = (bytes_left != 16'h0000) ? PhType : PhCheck;
      end
      PhType, PhPayload: begin
        kind        = (parse_phase == PhType) ? afd_pkg::KindType : afd_pkg::KindPayload;
        forward     = 1'b1;
        frame_sum   = frame_sum + b;
        bytes_left  = bytes_left - 16'h0001;
        parse_phase = (bytes_left != 16'h0000) ? PhPayload : PhCheck;
      end
      PhCheck: begin
        frame_sum = frame_sum + b;
        checked   = 1'b1;
        if (!last) begin
          latched_err = afd_pkg::StLength;
          parse_phase = PhDrain;
        end
      end
      default: begin
        if (latched_err == afd_pkg::StOk) latched_err = afd_pkg::StLength;
        parse_phase = PhDrain;
      end
    endcase

    if (last) begin
      // A latched error wins; a buffer that never reached its checksum is
      // short; otherwise the sum decides.
      if (latched_err != afd_pkg::StOk) verdict = latched_err;
      else if (!checked) verdict = afd_pkg::StLength;
      else verdict = (frame_sum == afd_pkg::SumGood) ? afd_pkg::StOk : afd_pkg::StChecksum;
      res.frame_length = hdr_length;
      res.status       = verdict;
      res.out_kind     = afd_pkg::KindVerdict;
      res.out_byte     = 8'h00;
      clear_parser();
      return 1'b1;
    end
    if (forward) begin
      res.out_byte = b;
      res.out_kind = kind;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Idle length for either side: mostly none or short, now and then long.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 45) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Offers one beat after an optional gap, waits for the handshake, then
  // records what the block owes for it. A typed row overrides the prediction.
  task automatic feed_byte(input logic [7:0] b, input logic last, input int unsigned gap,
                           input logic typed, input afd_pkg::result_t typed_res);
    afd_pkg::result_t predicted;
    logic             produces;
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= b;
    s_axis_tlast_i  <= last;
    do @(posedge clk_i); while (!s_axis_tready_o);
    beats_accepted++;
    produces = deframe_step(b, last, predicted);
    if (typed) frame_results_q = {frame_results_q, typed_res};
    else if (produces) frame_results_q = {frame_results_q, predicted};
  endtask

  // Waits until every owed result has arrived and the pipeline has emptied.
  task automatic wait_quiet(input int unsigned extra);
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (frame_results_q.size() != 0) @(posedge clk_i);
    repeat (extra) @(posedge clk_i);
  endtask

  task automatic write_delimiter(input logic [7:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    delimiter = value;
  endtask

  // Builds one random buffer. Most are well-formed frames with random content
  // and random lengths; the rest are truncated, overlong, wrongly started, header
  // noise or frames with a random checksum byte.
  task automatic build_buffer();
    int unsigned shape;
    int unsigned len;
    int unsigned cut;
    logic [7:0]  sum;
    logic [7:0]  b;
    buffer_bytes.delete();
    shape = $urandom_range(0, 99);
    if (shape < 7) begin
      b = 8'($urandom);
      if (b == delimiter) b = ~b;
      buffer_bytes = {buffer_bytes, b};
      repeat ($urandom_range(0, 5)) buffer_bytes = {buffer_bytes, 8'($urandom)};
    end else if (shape < 12) begin
      buffer_bytes = {buffer_bytes, delimiter};
      repeat ($urandom_range(0, 4)) buffer_bytes = {buffer_bytes, 8'($urandom)};
    end else begin
      // A frame longer than 255 bytes is rare because it costs many beats.
      if ($urandom_range(0, 99) == 0) len = $urandom_range(256, 270);
      else if ($urandom_range(0, 9) == 0) len = $urandom_range(9, 40);
      else len = $urandom_range(0, 8);
      buffer_bytes = {buffer_bytes, delimiter};
      buffer_bytes = {buffer_bytes, len[15:8]};
      buffer_bytes = {buffer_bytes, len[7:0]};
      sum = 8'h00;
      repeat (len) begin
        b = 8'($urandom);
        sum = sum + b;
        buffer_bytes = {buffer_bytes, b};
      end
      if ($urandom_range(0, 4) == 0) buffer_bytes = {buffer_bytes, 8'($urandom)};
      else buffer_bytes = {buffer_bytes, afd_pkg::SumGood - sum};
      if (shape < 22) begin
        // Cut anywhere between the delimiter and the checksum.
        cut = $urandom_range(1, buffer_bytes.size() - 1);
        buffer_bytes = buffer_bytes[0:cut-1];
      end else if (shape < 30) begin
        repeat ($urandom_range(1, 3)) buffer_bytes = {buffer_bytes, 8'($urandom)};
      end
    end
  endtask

  // Stimulus: reset, directed table, then random phases, each under its own
  // start delimiter.
  initial begin
    logic [7:0]  phase_delims [NumPhases];
    int unsigned target;
    logic        steady;
    rst_ni          <= 1'b0;
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i  <= 8'h00;
    s_axis_tlast_i  <= 1'b0;
    cfg_we_i        <= 1'b0;
    cfg_wdata_i     <= 8'h00;
    delimiter = afd_pkg::StartDelimReset;
    clear_parser();
    phase_delims[0] = 8'h00;
    phase_delims[1] = 8'hFF;
    phase_delims[2] = 8'($urandom);
    phase_delims[3] = afd_pkg::StartDelimReset;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int unsigned i = 0; i < NumDirected; i++) begin
      feed_byte(directed_rows[i].rx_byte, directed_rows[i].buffer_end, pick_gap(),
                directed_rows[i].typed, directed_rows[i].verdict);
    end

    for (int unsigned p = 0; p < NumPhases; p++) begin
      wait_quiet(QuietCycles);
      write_delimiter(phase_delims[p]);
      target = NumDirected + (ItemBudget - NumDirected) * (p + 1) / NumPhases;
      while (beats_accepted < target) begin
        build_buffer();
        // Some buffers send their bytes back to back, without any idle cycle.
        steady = ($urandom_range(0, 3) == 0);
        for (int unsigned i = 0; i < buffer_bytes.size(); i++) begin
          feed_byte(buffer_bytes[i], i == buffer_bytes.size() - 1,
                    steady ? 0 : pick_gap(), 1'b0, '0);
        end
      end
    end

    wait_quiet(QuietCycles + 4);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Result side: random stalls, runs of steady ready, and once a long
  // hold-off while the sender keeps offering, so the block backs up.
  initial begin
    logic held;
    int unsigned stall;
    held = 1'b0;
    m_axis_tready_i <= 1'b0;
    @(posedge clk_i);
    forever begin
      if (!held && beats_accepted >= HoldAfter) begin
        held = 1'b1;
        m_axis_tready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end
      stall = pick_gap();
      if (stall > 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      repeat (($urandom_range(0, 9) == 0) ? 60 : $urandom_range(1, 8)) @(posedge clk_i);
    end
  end

  // Every accepted result beat is compared with the oldest owed result.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (frame_results_q.size() == 0) begin
        $error("unexpected result beat: tdata %h tuser %h", m_axis_tdata_o, m_axis_tuser_o);
        mismatch_count++;
      end else begin
        oldest_result = frame_results_q.pop_front();
        if (m_axis_tdata_o[7:0] !== oldest_result.out_byte) begin
          $error("out_byte: expected %h, got %h", oldest_result.out_byte,
                 m_axis_tdata_o[7:0]);
          mismatch_count++;
        end
        if (m_axis_tuser_o !== oldest_result.out_kind) begin
          $error("out_kind: expected %0d, got %0d", oldest_result.out_kind, m_axis_tuser_o);
          mismatch_count++;
        end
        if (m_axis_tdata_o[9:8] !== oldest_result.status) begin
          $error("status: expected %0d, got %0d", oldest_result.status,
                 m_axis_tdata_o[9:8]);
          mismatch_count++;
        end
        if (m_axis_tdata_o[25:10] !== oldest_result.frame_length) begin
          $error("frame_length: expected %h, got %h", oldest_result.frame_length,
                 m_axis_tdata_o[25:10]);
          mismatch_count++;
        end
        if (m_axis_tdata_o[31:26] !== 6'd0) begin
          $error("tdata padding: expected 0, got %h", m_axis_tdata_o[31:26]);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

endmodule

FILE: filelist.f
src/afd_pkg.sv
src/afd_in_reg.sv
src/afd_core.sv
src/afd_out_reg.sv
src/api_frame_deframer_checker_unit.sv
verif/api_frame_deframer_checker_unit_tb.sv
